[src/fpr_pkg.sv]
// Shared constants, types and helper functions of the frame buffer rasterizer.
package fpr_pkg;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int XW = $clog2(MAX_W);
  localparam int YW = $clog2(MAX_H);
  localparam int MEM_DEPTH = MAX_W * MAX_H;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int WW = $clog2(MAX_W + 1);
  localparam int HW = $clog2(MAX_H + 1);
  localparam int CFGW = 9;
  localparam int CW = 16;
  localparam int COLW = 24;
  localparam int EW = 37;
  localparam int JQ_DEPTH = 4;
  localparam int JQ_PW = $clog2(JQ_DEPTH);

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_PLOT = 3'd1;
  localparam logic [2:0] MODE_RECT = 3'd2;
  localparam logic [2:0] MODE_OUTLINE = 3'd3;
  localparam logic [2:0] MODE_LINE = 3'd4;
  localparam logic [2:0] MODE_TRI = 3'd5;
  localparam logic [2:0] MODE_READ = 3'd6;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    JOB_CLEAR,
    JOB_BOX,
    JOB_LINE,
    JOB_TRI,
    JOB_READ
  } job_kind_e;

  typedef struct packed {
    job_kind_e kind;
    logic [COLW-1:0] color;
    logic in_frame;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [XW-1:0] lo_x;
    logic [XW-1:0] hi_x;
    logic [YW-1:0] lo_y;
    logic [YW-1:0] hi_y;
  } job_t;

  typedef struct packed {
    logic [WW-1:0] aw;
    logic [HW-1:0] ah;
  } clip_t;

  function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(y) * AW'(MAX_W) + AW'(x);
  endfunction

  function automatic logic signed [16:0] sx17(input logic [CW-1:0] v);
    return $signed({v[CW-1], v});
  endfunction

endpackage

[src/fpr_job_fifo.sv]
// Short job queue between the command front end and the pixel engine.
module fpr_job_fifo import fpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t entries_q [JQ_DEPTH];
  logic [JQ_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JQ_PW:0] count_q;

  assign full_o = (count_q == (JQ_PW+1)'(JQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

[src/fpr_front.sv]
// Command front end: clipping registers, command decode and job generation.
module fpr_front import fpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       mode_i,
  input  logic [CW-1:0]    first_x_i,
  input  logic [CW-1:0]    first_y_i,
  input  logic [CW-1:0]    second_x_i,
  input  logic [CW-1:0]    second_y_i,
  input  logic [CW-1:0]    third_x_i,
  input  logic [CW-1:0]    third_y_i,
  input  logic [COLW-1:0]  draw_color_i,
  input  logic [7:0]       border_width_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFGW-1:0]  cfg_data_i,
  input  logic             init_busy_i,
  input  logic             jq_full_i,
  output logic             jq_push_o,
  output job_t             jq_data_o,
  output clip_t            clip_o
);

  logic [CFGW-1:0] wcfg_q, hcfg_q;
  logic cmd_valid_q;
  logic [1:0] band_q;
  logic [2:0] mode_q;
  logic [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [COLW-1:0] col_q;
  logic [7:0] bw_q;

  logic signed [19:0] ox, oy, bw, bh, ex, ey, ex_c, ey_c, lx, ly, aw20, ah20, t20;
  logic box_ne, tri_ne, want, last, in_frame;
  logic signed [16:0] tmin_x, tmax_x, tmin_y, tmax_y, tlo_x, thi_x, tlo_y, thi_y;
  logic signed [16:0] aw17, ah17;

  function automatic logic signed [19:0] sx20(input logic [CW-1:0] v);
    return $signed({{4{v[CW-1]}}, v});
  endfunction

  function automatic logic signed [16:0] min3(input logic signed [16:0] a,
      input logic signed [16:0] b, input logic signed [16:0] c);
    logic signed [16:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [16:0] max3(input logic signed [16:0] a,
      input logic signed [16:0] b, input logic signed [16:0] c);
    logic signed [16:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  always_comb begin
    if (wcfg_q == '0) clip_o.aw = WW'(1);
    else if (wcfg_q > CFGW'(MAX_W)) clip_o.aw = WW'(MAX_W);
    else clip_o.aw = WW'(wcfg_q);
    if (hcfg_q == '0) clip_o.ah = HW'(1);
    else if (hcfg_q > CFGW'(MAX_H)) clip_o.ah = HW'(MAX_H);
    else clip_o.ah = HW'(hcfg_q);
  end

  assign aw20 = $signed(20'(clip_o.aw));
  assign ah20 = $signed(20'(clip_o.ah));
  assign aw17 = $signed(17'(clip_o.aw));
  assign ah17 = $signed(17'(clip_o.ah));
  assign t20 = $signed({12'b0, bw_q});

  always_comb begin
    ox = sx20(ax_q);
    oy = sx20(ay_q);
    bw = sx20(bx_q);
    bh = sx20(by_q);
    case (mode_q)
      MODE_PLOT: begin
        bw = 20'sd1;
        bh = 20'sd1;
      end
      MODE_OUTLINE: begin
        case (band_q)
          2'd0: bh = t20;
          2'd1: begin
            oy = sx20(ay_q) + sx20(by_q) - t20;
            bh = t20;
          end
          2'd2: bw = t20;
          default: begin
            ox = sx20(ax_q) + sx20(bx_q) - t20;
            bw = t20;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign ex = ox + bw;
  assign ey = oy + bh;
  assign ex_c = (ex > aw20) ? aw20 : ex;
  assign ey_c = (ey > ah20) ? ah20 : ey;
  assign lx = ox[19] ? 20'sd0 : ox;
  assign ly = oy[19] ? 20'sd0 : oy;
  assign box_ne = (lx < ex_c) && (ly < ey_c);

  assign tmin_x = min3(sx17(ax_q), sx17(bx_q), sx17(cx_q));
  assign tmax_x = max3(sx17(ax_q), sx17(bx_q), sx17(cx_q));
  assign tmin_y = min3(sx17(ay_q), sx17(by_q), sx17(cy_q));
  assign tmax_y = max3(sx17(ay_q), sx17(by_q), sx17(cy_q));
  assign tlo_x = tmin_x[16] ? 17'sd0 : tmin_x;
  assign tlo_y = tmin_y[16] ? 17'sd0 : tmin_y;
  assign thi_x = (tmax_x > aw17 - 17'sd1) ? aw17 - 17'sd1 : tmax_x;
  assign thi_y = (tmax_y > ah17 - 17'sd1) ? ah17 - 17'sd1 : tmax_y;
  assign tri_ne = (tlo_x <= thi_x) && (tlo_y <= thi_y);

  assign in_frame = !ax_q[CW-1] && !ay_q[CW-1] && (ax_q < CW'(clip_o.aw))
                    && (ay_q < CW'(clip_o.ah));

  always_comb begin
    jq_data_o.kind = JOB_BOX;
    jq_data_o.color = col_q;
    jq_data_o.in_frame = in_frame;
    jq_data_o.ax = ax_q;
    jq_data_o.ay = ay_q;
    jq_data_o.bx = bx_q;
    jq_data_o.by = by_q;
    jq_data_o.cx = cx_q;
    jq_data_o.cy = cy_q;
    jq_data_o.lo_x = lx[XW-1:0];
    jq_data_o.lo_y = ly[YW-1:0];
    jq_data_o.hi_x = XW'(ex_c - 20'sd1);
    jq_data_o.hi_y = YW'(ey_c - 20'sd1);
    want = 1'b0;
    case (mode_q)
      MODE_CLEAR: begin
        jq_data_o.kind = JOB_CLEAR;
        want = 1'b1;
      end
      MODE_PLOT, MODE_RECT, MODE_OUTLINE: want = box_ne;
      MODE_LINE: begin
        jq_data_o.kind = JOB_LINE;
        want = 1'b1;
      end
      MODE_TRI: begin
        jq_data_o.kind = JOB_TRI;
        jq_data_o.lo_x = tlo_x[XW-1:0];
        jq_data_o.lo_y = tlo_y[YW-1:0];
        jq_data_o.hi_x = thi_x[XW-1:0];
        jq_data_o.hi_y = thi_y[YW-1:0];
        want = tri_ne;
      end
      MODE_READ: begin
        jq_data_o.kind = JOB_READ;
        jq_data_o.lo_x = ax_q[XW-1:0];
        jq_data_o.lo_y = ay_q[YW-1:0];
        want = 1'b1;
      end
      default: want = 1'b0;
    endcase
  end

  assign last = (mode_q != MODE_OUTLINE) || (band_q == 2'd3);
  assign jq_push_o = cmd_valid_q && !jq_full_i && want;
  assign full = cmd_valid_q || init_busy_i;

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      mode_q <= mode_i;
      ax_q <= first_x_i;
      ay_q <= first_y_i;
      bx_q <= second_x_i;
      by_q <= second_y_i;
      cx_q <= third_x_i;
      cy_q <= third_y_i;
      col_q <= draw_color_i;
      bw_q <= border_width_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcfg_q <= CFGW'(MAX_W);
      hcfg_q <= CFGW'(MAX_H);
      cmd_valid_q <= 1'b0;
      band_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WIDTH) wcfg_q <= cfg_data_i;
        else hcfg_q <= cfg_data_i;
      end
      if (push && !full) begin
        cmd_valid_q <= 1'b1;
        band_q <= '0;
      end else if (cmd_valid_q && !jq_full_i) begin
        if (last) cmd_valid_q <= 1'b0;
        else band_q <= band_q + 1'b1;
      end
    end
  end

endmodule

[src/fpr_back.sv]
// Pixel engine: frame store, clear sweep, box, line and triangle walkers, pixel read.
module fpr_back import fpr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clip_t           clip_i,
  input  logic            jq_empty_i,
  input  job_t            jq_data_i,
  output logic            jq_pop_o,
  output logic            init_busy_o,
  input  logic            pop,
  output logic            empty,
  output logic [COLW-1:0] read_color_o,
  output logic            read_inside_o
);

  localparam logic [3:0] ST_SWEEP = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_BOX = 4'd2;
  localparam logic [3:0] ST_LINE = 4'd3;
  localparam logic [3:0] ST_TSET = 4'd4;
  localparam logic [3:0] ST_TRI = 4'd5;
  localparam logic [3:0] ST_READ = 4'd6;
  localparam logic [3:0] ST_RWAIT = 4'd7;

  logic [COLW-1:0] mem [MEM_DEPTH];
  logic [COLW-1:0] rd_q;

  logic [3:0] state_q;
  logic init_q;
  job_t job_q;
  logic [CW-1:0] px_q, py_q;
  logic [AW-1:0] sweep_q;
  logic [16:0] ldx_q;
  logic signed [17:0] ldy_q;
  logic lsxn_q, lsyn_q;
  logic signed [19:0] err_q;
  logic [2:0] step_q;
  logic signed [33:0] prod_q;
  logic signed [EW-1:0] erow_q [3];
  logic signed [EW-1:0] ecur_q [3];
  logic res_valid_q, res_inside_q;
  logic [COLW-1:0] res_color_q;

  logic we, rd_en;
  logic [AW-1:0] wr_addr;
  logic [COLW-1:0] wr_data;
  logic [AW-1:0] walk_addr;
  logic row_end, last_row;

  logic signed [16:0] hdx, hdy;
  logic [16:0] hadx, hady;
  logic signed [20:0] e2;
  logic c1, c2, line_done, line_in;
  logic signed [19:0] err_d;

  logic signed [16:0] vx [3];
  logic signed [16:0] vy [3];
  logic signed [16:0] sdx [3];
  logic signed [16:0] sdy [3];
  logic signed [16:0] mul_a, mul_b;
  logic tri_pass, all_pos, all_neg;
  logic [1:0] eidx;

  assign init_busy_o = init_q;
  assign empty = !res_valid_q;
  assign read_color_o = res_color_q;
  assign read_inside_o = res_inside_q;

  assign walk_addr = pix_addr(px_q[XW-1:0], py_q[YW-1:0]);
  assign row_end = (px_q[XW-1:0] == job_q.hi_x);
  assign last_row = (py_q[YW-1:0] == job_q.hi_y);

  assign hdx = sx17(jq_data_i.bx) - sx17(jq_data_i.ax);
  assign hdy = sx17(jq_data_i.by) - sx17(jq_data_i.ay);
  assign hadx = hdx[16] ? 17'(-hdx) : 17'(hdx);
  assign hady = hdy[16] ? 17'(-hdy) : 17'(hdy);

  assign e2 = {err_q, 1'b0};
  assign c1 = e2 >= 21'(ldy_q);
  assign c2 = e2 <= $signed({4'b0, ldx_q});
  assign err_d = err_q + (c1 ? 20'(ldy_q) : 20'sd0) + (c2 ? $signed({3'b0, ldx_q}) : 20'sd0);
  assign line_done = (px_q == job_q.bx) && (py_q == job_q.by);
  assign line_in = !px_q[CW-1] && !py_q[CW-1] && (px_q < CW'(clip_i.aw))
                   && (py_q < CW'(clip_i.ah));

  assign vx[0] = sx17(job_q.ax);
  assign vy[0] = sx17(job_q.ay);
  assign vx[1] = sx17(job_q.bx);
  assign vy[1] = sx17(job_q.by);
  assign vx[2] = sx17(job_q.cx);
  assign vy[2] = sx17(job_q.cy);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sdx[k] = vy[(k + 1) % 3] - vy[k];
      sdy[k] = vx[k] - vx[(k + 1) % 3];
    end
  end

  always_comb begin
    case (step_q)
      3'd0: begin
        mul_a = $signed(17'(job_q.lo_x)) - vx[0];
        mul_b = sdx[0];
      end
      3'd1: begin
        mul_a = $signed(17'(job_q.lo_y)) - vy[0];
        mul_b = sdy[0];
      end
      3'd2: begin
        mul_a = $signed(17'(job_q.lo_x)) - vx[1];
        mul_b = sdx[1];
      end
      3'd3: begin
        mul_a = $signed(17'(job_q.lo_y)) - vy[1];
        mul_b = sdy[1];
      end
      3'd4: begin
        mul_a = $signed(17'(job_q.lo_x)) - vx[2];
        mul_b = sdx[2];
      end
      3'd5: begin
        mul_a = $signed(17'(job_q.lo_y)) - vy[2];
        mul_b = sdy[2];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign eidx = 2'((step_q - 3'd1) >> 1);

  assign all_pos = !ecur_q[0][EW-1] && !ecur_q[1][EW-1] && !ecur_q[2][EW-1];
  assign all_neg = (ecur_q[0][EW-1] || ecur_q[0] == '0) && (ecur_q[1][EW-1] || ecur_q[1] == '0)
                   && (ecur_q[2][EW-1] || ecur_q[2] == '0);
  assign tri_pass = all_pos || all_neg;

  always_comb begin
    we = 1'b0;
    wr_addr = walk_addr;
    wr_data = job_q.color;
    case (state_q)
      ST_SWEEP: begin
        we = 1'b1;
        wr_addr = sweep_q;
        wr_data = init_q ? '0 : job_q.color;
      end
      ST_BOX: we = 1'b1;
      ST_LINE: we = line_in;
      ST_TRI: we = tri_pass;
      default: we = 1'b0;
    endcase
  end

  assign rd_en = (state_q == ST_READ) && !res_valid_q && job_q.in_frame;
  assign jq_pop_o = (state_q == ST_IDLE) && !jq_empty_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[pix_addr(job_q.lo_x, job_q.lo_y)];
  end

  always_ff @(posedge clk_i) begin
    if (jq_pop_o) job_q <= jq_data_i;
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        px_q <= jq_data_i.ax;
        py_q <= jq_data_i.ay;
        if (jq_data_i.kind == JOB_BOX || jq_data_i.kind == JOB_TRI) begin
          px_q <= CW'(jq_data_i.lo_x);
          py_q <= CW'(jq_data_i.lo_y);
        end
        ldx_q <= hadx;
        ldy_q <= -$signed({1'b0, hady});
        lsxn_q <= hdx[16];
        lsyn_q <= !hdy[16] ? 1'b0 : 1'b1;
        err_q <= $signed({3'b0, hadx}) - $signed({3'b0, hady});
      end
      ST_BOX: begin
        if (row_end) begin
          px_q <= CW'(job_q.lo_x);
          py_q <= py_q + 1'b1;
        end else begin
          px_q <= px_q + 1'b1;
        end
      end
      ST_LINE: begin
        err_q <= err_d;
        if (c1) px_q <= lsxn_q ? px_q - 1'b1 : px_q + 1'b1;
        if (c2) py_q <= lsyn_q ? py_q - 1'b1 : py_q + 1'b1;
      end
      ST_TSET: begin
        if (step_q != 3'd0 && step_q != 3'd7) begin
          if (step_q[0]) erow_q[eidx] <= EW'(prod_q);
          else erow_q[eidx] <= erow_q[eidx] + EW'(prod_q);
        end
        if (step_q == 3'd7) begin
          for (int k = 0; k < 3; k++) ecur_q[k] <= erow_q[k];
        end
      end
      ST_TRI: begin
        if (row_end) begin
          px_q <= CW'(job_q.lo_x);
          py_q <= py_q + 1'b1;
          for (int k = 0; k < 3; k++) begin
            erow_q[k] <= erow_q[k] + EW'(sdy[k]);
            ecur_q[k] <= erow_q[k] + EW'(sdy[k]);
          end
        end else begin
          px_q <= px_q + 1'b1;
          for (int k = 0; k < 3; k++) ecur_q[k] <= ecur_q[k] + EW'(sdx[k]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      init_q <= 1'b1;
      sweep_q <= '0;
      step_q <= '0;
      res_valid_q <= 1'b0;
      res_inside_q <= 1'b0;
      res_color_q <= '0;
    end else begin
      if (pop && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == AW'(MEM_DEPTH - 1)) begin
            init_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!jq_empty_i) begin
            sweep_q <= '0;
            step_q <= '0;
            case (jq_data_i.kind)
              JOB_CLEAR: state_q <= ST_SWEEP;
              JOB_BOX: state_q <= ST_BOX;
              JOB_LINE: state_q <= ST_LINE;
              JOB_TRI: state_q <= ST_TSET;
              JOB_READ: state_q <= ST_READ;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_BOX: if (row_end && last_row) state_q <= ST_IDLE;
        ST_LINE: if (line_done) state_q <= ST_IDLE;
        ST_TSET: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd7) state_q <= ST_TRI;
        end
        ST_TRI: if (row_end && last_row) state_q <= ST_IDLE;
        ST_READ: begin
          if (!res_valid_q) begin
            if (job_q.in_frame) begin
              state_q <= ST_RWAIT;
            end else begin
              res_valid_q <= 1'b1;
              res_inside_q <= 1'b0;
              res_color_q <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_RWAIT: begin
          res_valid_q <= 1'b1;
          res_inside_q <= 1'b1;
          res_color_q <= rd_q;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/framebuffer_primitive_rasterizer.sv]
// Top level of the frame buffer rasterizer: front end, job queue and pixel engine.
//
//   Channel   Direction  Transfer when        Contents
//   command   in         push & !full         mode, three vertices, color, border width
//   result    out        pop & !empty         read_color, read_inside (read commands only)
//   config    in         cfg_we_i             frame width (0) or frame height (1)
//
// The pixel engine visits one pixel per cycle while drawing: a box or triangle walks its
// clipped bounding box, a line its Bresenham steps (writing only pixels inside the frame),
// a clear the whole frame store; each job is first taken from the queue in the idle state.
// A triangle first sets up its edge values on the shared edge multiplier; a read addresses
// the frame store, then captures the color. After reset the frame store is swept to black
// while full stays high. The front end holds one command and the job queue four jobs, so
// commands are taken while earlier ones draw; a read waits in the engine while a result is
// pending, holding up every job behind it.
module framebuffer_primitive_rasterizer import fpr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      mode_i,
  input  logic [CW-1:0]   first_x_i,
  input  logic [CW-1:0]   first_y_i,
  input  logic [CW-1:0]   second_x_i,
  input  logic [CW-1:0]   second_y_i,
  input  logic [CW-1:0]   third_x_i,
  input  logic [CW-1:0]   third_y_i,
  input  logic [COLW-1:0] draw_color_i,
  input  logic [7:0]      border_width_i,
  output logic            empty,
  input  logic            pop,
  output logic [COLW-1:0] read_color_o,
  output logic            read_inside_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CFGW-1:0] cfg_data_i
);

  logic init_busy, jq_full, jq_push, jq_pop, jq_empty;
  job_t jq_wdata, jq_rdata;
  clip_t clip;

  fpr_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .mode_i, .first_x_i, .first_y_i, .second_x_i, .second_y_i, .third_x_i, .third_y_i,
    .draw_color_i, .border_width_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .init_busy_i(init_busy), .jq_full_i(jq_full), .jq_push_o(jq_push),
    .jq_data_o(jq_wdata), .clip_o(clip)
  );

  fpr_job_fifo u_queue (
    .clk_i, .rst_ni, .push_i(jq_push), .data_i(jq_wdata), .full_o(jq_full),
    .pop_i(jq_pop), .data_o(jq_rdata), .empty_o(jq_empty)
  );

  fpr_back u_back (
    .clk_i, .rst_ni, .clip_i(clip), .jq_empty_i(jq_empty), .jq_data_i(jq_rdata),
    .jq_pop_o(jq_pop), .init_busy_o(init_busy), .pop, .empty,
    .read_color_o, .read_inside_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_push |-> !jq_full) else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_pop |-> !jq_empty) else $error("job popped from an empty queue");

  a_init_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> full) else $error("command accepted during frame store sweep");

  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full) else $error("front end took a command without holding it");

endmodule
